### hdl/mfv_pkg.sv
`default_nettype none

package mfv_pkg;

   // Default list capacity of the value store
   localparam int CAPACITY_DEF = 256;

   // Widths of the item fields
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 9;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic        [COUNT_W-1:0] count_type;

endpackage

`default_nettype wire

### hdl/mfv_if.sv
`default_nettype none

interface mfv_req_if;
   import mfv_pkg::*;

   logic      valid;
   logic      ready;
   value_type sample_value;
   logic      is_final;

   modport source (output valid, output sample_value, output is_final, input ready);
   modport sink   (input valid, input sample_value, input is_final, output ready);
endinterface

interface mfv_rsp_if;
   import mfv_pkg::*;

   logic      valid;
   logic      ready;
   value_type most_value;
   count_type most_count;
   value_type least_value;
   count_type least_count;
   logic      overflowed;

   modport source (output valid, output most_value, output most_count,
                   output least_value, output least_count, output overflowed,
                   input ready);
   modport sink   (input valid, input most_value, input most_count,
                   input least_value, input least_count, input overflowed,
                   output ready);
endinterface

`default_nettype wire

### hdl/mfv_store.sv
`default_nettype none

module mfv_store
   import mfv_pkg::*;
#(
   parameter int DEPTH = CAPACITY_DEF,
   parameter int AW    = 8
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire value_type     wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output      value_type     rd_data
);

   value_type mem [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### hdl/most_and_least_frequent_value_top.sv
// Most and least frequent value of a list.
// req_if carries one signed 32-bit sample per item; is_final marks the last
// sample of a list (that sample belongs to the list). While loading, one item
// is accepted every cycle and written to the value store. Samples beyond
// CAPACITY are dropped and set the overflowed flag of the result.
// After the final item the block drops ready and scans the store with a
// single shared comparator and one registered memory read port. For each
// index i it reads the candidate and compares it with the entries from 0 on:
// a sample that already occurred earlier stops the scan at the earlier copy,
// while a first occurrence is compared with all n held samples; its count is
// folded into most and least, and the result goes to the output register.
// rsp_if carries one item per list: the value with the highest count and the
// value with the lowest count, ties going to the earliest first occurrence.
// The output register holds the result while the receiver stalls; the block
// takes the next list's samples meanwhile, and waits only if a second result
// is ready before the first one was taken.
// Reset (synchronous, active high) empties the list and drops any pending
// result; the store contents are not cleared and are never read before being
// written.
`default_nettype none

module most_and_least_frequent_value_top
   import mfv_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   mfv_req_if.sink    req_if,
   mfv_rsp_if.source  rsp_if
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // store address
   localparam int LW = $clog2(CAPACITY + 1);                    // sample count
   localparam int CW = $clog2(CAPACITY + 2);                    // running counts

   // Sequencer states
   localparam logic [2:0] S_LOAD = 3'd0;  // take samples
   localparam logic [2:0] S_RDI  = 3'd1;  // read candidate value at i
   localparam logic [2:0] S_LDI  = 3'd2;  // latch candidate, start scan at 0
   localparam logic [2:0] S_CMP  = 3'd3;  // compare store[j] with candidate
   localparam logic [2:0] S_UPD  = 3'd4;  // fold count into most / least
   localparam logic [2:0] S_DONE = 3'd5;  // hand result to output register

   logic [2:0]    state_ff, state_in;
   logic [LW-1:0] load_cnt_ff, load_cnt_in;
   logic          ovf_ff, ovf_in;
   logic [LW-1:0] i_ff, i_in;
   logic [LW-1:0] j_ff, j_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   value_type     vi_ff, vi_in;
   value_type     most_val_ff, most_val_in;
   logic [CW-1:0] most_cnt_ff, most_cnt_in;
   value_type     least_val_ff, least_val_in;
   logic [CW-1:0] least_cnt_ff, least_cnt_in;

   logic          rsp_valid_ff, rsp_valid_in;
   value_type     rsp_most_val_ff, rsp_most_val_in;
   count_type     rsp_most_cnt_ff, rsp_most_cnt_in;
   value_type     rsp_least_val_ff, rsp_least_val_in;
   count_type     rsp_least_cnt_ff, rsp_least_cnt_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic          req_acc;
   logic          full;
   logic          wr_en;
   logic [AW-1:0] rd_addr;
   value_type     rd_q;
   logic [LW-1:0] last_idx;
   logic [LW-1:0] j_next;
   logic          same;
   logic          i_last;
   logic          rsp_free;
   logic [CW+COUNT_W-1:0] most_ext;
   logic [CW+COUNT_W-1:0] least_ext;

   assign req_if.ready = (state_ff == S_LOAD);
   assign req_acc      = req_if.valid && req_if.ready;
   assign full         = (load_cnt_ff == LW'(CAPACITY));
   assign wr_en        = req_acc && !full;
   assign last_idx     = load_cnt_ff - 1'b1;
   assign j_next       = j_ff + 1'b1;
   assign same         = (rd_q == vi_ff);
   assign i_last       = (i_ff == last_idx);
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   // Counts are reported in the 9-bit field: zero-extend or truncate
   assign most_ext  = {{COUNT_W{1'b0}}, most_cnt_ff};
   assign least_ext = {{COUNT_W{1'b0}}, least_cnt_ff};

   mfv_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (load_cnt_ff[AW-1:0]),
      .wr_data (req_if.sample_value),
      .rd_addr (rd_addr),
      .rd_data (rd_q)
   );

   // Read address: candidate at i, then scan from 0 one entry ahead
   always_comb begin
      case (state_ff)
         S_LDI:   rd_addr = '0;
         S_CMP:   rd_addr = j_next[AW-1:0];
         default: rd_addr = i_ff[AW-1:0];
      endcase
   end

   always_comb begin
      state_in         = state_ff;
      load_cnt_in      = load_cnt_ff;
      ovf_in           = ovf_ff;
      i_in             = i_ff;
      j_in             = j_ff;
      cnt_in           = cnt_ff;
      vi_in            = vi_ff;
      most_val_in      = most_val_ff;
      most_cnt_in      = most_cnt_ff;
      least_val_in     = least_val_ff;
      least_cnt_in     = least_cnt_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_if.ready;
      rsp_most_val_in  = rsp_most_val_ff;
      rsp_most_cnt_in  = rsp_most_cnt_ff;
      rsp_least_val_in = rsp_least_val_ff;
      rsp_least_cnt_in = rsp_least_cnt_ff;
      rsp_ovf_in       = rsp_ovf_ff;

      case (state_ff)
         S_LOAD: begin
            if (req_acc) begin
               // Store the sample, or drop it and flag overflow when full
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  load_cnt_in = load_cnt_ff + 1'b1;
               end
               if (req_if.is_final) begin
                  i_in         = '0;
                  most_val_in  = '0;
                  most_cnt_in  = '0;
                  least_val_in = '0;
                  least_cnt_in = CW'(CAPACITY + 1);
                  state_in     = S_RDI;
               end
            end
         end
         S_RDI: begin
            state_in = S_LDI;
         end
         S_LDI: begin
            vi_in    = rd_q;
            j_in     = '0;
            cnt_in   = '0;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (same && (j_ff < i_ff)) begin
               // Value occurred earlier: already counted, skip it
               if (i_last) begin
                  state_in = S_DONE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_RDI;
               end
            end else begin
               cnt_in = cnt_ff + CW'(same);
               if (j_ff == last_idx) begin
                  state_in = S_UPD;
               end else begin
                  j_in = j_next;
               end
            end
         end
         S_UPD: begin
            // Strict compares keep the earliest value on ties
            if (cnt_ff > most_cnt_ff) begin
               most_cnt_in = cnt_ff;
               most_val_in = vi_ff;
            end
            if (cnt_ff < least_cnt_ff) begin
               least_cnt_in = cnt_ff;
               least_val_in = vi_ff;
            end
            if (i_last) begin
               state_in = S_DONE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_RDI;
            end
         end
         S_DONE: begin
            // Hold until the output register is free, then empty the list
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_most_val_in  = most_val_ff;
               rsp_most_cnt_in  = most_ext[COUNT_W-1:0];
               rsp_least_val_in = least_val_ff;
               rsp_least_cnt_in = least_ext[COUNT_W-1:0];
               rsp_ovf_in       = ovf_ff;
               load_cnt_in      = '0;
               ovf_in           = 1'b0;
               state_in         = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         load_cnt_ff  <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff             <= i_in;
      j_ff             <= j_in;
      cnt_ff           <= cnt_in;
      vi_ff            <= vi_in;
      most_val_ff      <= most_val_in;
      most_cnt_ff      <= most_cnt_in;
      least_val_ff     <= least_val_in;
      least_cnt_ff     <= least_cnt_in;
      rsp_most_val_ff  <= rsp_most_val_in;
      rsp_most_cnt_ff  <= rsp_most_cnt_in;
      rsp_least_val_ff <= rsp_least_val_in;
      rsp_least_cnt_ff <= rsp_least_cnt_in;
      rsp_ovf_ff       <= rsp_ovf_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.most_value  = rsp_most_val_ff;
   assign rsp_if.most_count  = rsp_most_cnt_ff;
   assign rsp_if.least_value = rsp_least_val_ff;
   assign rsp_if.least_count = rsp_least_cnt_ff;
   assign rsp_if.overflowed  = rsp_ovf_ff;

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps

import mfv_pkg::*;

typedef struct {
   value_type most_value;
   count_type most_count;
   value_type least_value;
   count_type least_count;
   logic      overflowed;
} freq_result_type;

class freq_scoreboard;
   int              capacity;
   value_type       list_held[$];
   bit              list_overflow;
   freq_result_type expected_results[$];
   int              error_count;
   int              result_index;

   function new(int cap);
      capacity      = cap;
      list_overflow = 1'b0;
      error_count   = 0;
      result_index  = 0;
   endfunction

   function int pending();
      return expected_results.size();
   endfunction

   // Count distinct values in order of first occurrence; strict compares keep the earliest.
   function freq_result_type count_frequencies();
      freq_result_type r;
      bit              seen[];
      int              n, i, j, cnt, most_cnt, least_cnt;
      n = list_held.size();
      seen = new[n];
      most_cnt = 0;
      least_cnt = capacity + 1;
      r.most_value = '0;
      r.least_value = '0;
      for (i = 0; i < n; i++) begin
         if (seen[i]) continue;
         cnt = 1;
         for (j = i + 1; j < n; j++) begin
            if (list_held[j] == list_held[i]) begin
               seen[j] = 1'b1;
               cnt++;
            end
         end
         if (cnt > most_cnt) begin
            most_cnt = cnt;
            r.most_value = list_held[i];
         end
         if (cnt < least_cnt) begin
            least_cnt = cnt;
            r.least_value = list_held[i];
         end
      end
      r.most_count  = count_type'(most_cnt);
      r.least_count = count_type'(least_cnt);
      r.overflowed  = list_overflow;
      return r;
   endfunction

   function void note_sample(value_type v, logic last);
      if (list_held.size() < capacity) list_held.push_back(v);
      else list_overflow = 1'b1;
      if (last) begin
         expected_results.push_back(count_frequencies());
         list_held.delete();
         list_overflow = 1'b0;
      end
   endfunction

   task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      error_count++;
   endtask

   task check_result(freq_result_type got);
      freq_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("result with no list pending: most %0d x%0d",
                                   got.most_value, got.most_count));
         return;
      end
      want = expected_results.pop_front();
      if (got.most_value !== want.most_value)
         report_mismatch($sformatf("list %0d most_value %0d, want %0d",
                                   result_index, got.most_value, want.most_value));
      if (got.most_count !== want.most_count)
         report_mismatch($sformatf("list %0d most_count %0d, want %0d",
                                   result_index, got.most_count, want.most_count));
      if (got.least_value !== want.least_value)
         report_mismatch($sformatf("list %0d least_value %0d, want %0d",
                                   result_index, got.least_value, want.least_value));
      if (got.least_count !== want.least_count)
         report_mismatch($sformatf("list %0d least_count %0d, want %0d",
                                   result_index, got.least_count, want.least_count));
      if (got.overflowed !== want.overflowed)
         report_mismatch($sformatf("list %0d overflowed %0b, want %0b",
                                   result_index, got.overflowed, want.overflowed));
      result_index++;
   endtask
endclass

module testbench;
   localparam int        CAPACITY     = CAPACITY_DEF;
   localparam int        CYCLE_LIMIT  = 3_000_000;
   localparam int        LONG_HOLD    = 2000;
   localparam int        DRAIN_CYCLES = 200;
   localparam int        RANDOM_ITEMS = 300;
   localparam value_type VALUE_MIN    = value_type'(32'h8000_0000);
   localparam value_type VALUE_MAX    = value_type'(32'h7FFF_FFFF);

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;

   mfv_req_if req ();
   mfv_rsp_if rsp ();

   most_and_least_frequent_value_top #(.CAPACITY(CAPACITY)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   freq_scoreboard sb = new(CAPACITY);

   // Sender state: bursts of random length, random gaps in between.
   bit        gapless = 1'b0;
   int        burst_left = 0;
   int        random_items = 0;
   bit        hold_requested = 1'b0;
   value_type list_buf[$];
   value_type value_pool[$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: a stuck handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Note every accepted sample; the prediction is made on the final one.
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready)
         sb.note_sample(req.sample_value, req.is_final);
   end

   // Compare every accepted result against the oldest prediction.
   always @(posedge clock) begin
      freq_result_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.most_value  = rsp.most_value;
         got.most_count  = rsp.most_count;
         got.least_value = rsp.least_value;
         got.least_count = rsp.least_count;
         got.overflowed  = rsp.overflowed;
         sb.check_result(got);
      end
   end

   // Receiver: switch between stall patterns, each held for a random stretch, and
   // hold off completely for a long stretch when the stimulus asks for it.
   initial begin : receiver
      int mode;
      int mode_left;
      int phase;
      int k;
      mode = 0;
      mode_left = 0;
      phase = 0;
      rsp.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_requested) begin
            hold_requested = 1'b0;
            rsp.ready <= 1'b0;
            for (k = 0; k < LONG_HOLD; k++) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(64, 512);
            end
            mode_left--;
            phase++;
            case (mode)
               0: begin
                  rsp.ready <= 1'b1;
               end
               1: begin
                  rsp.ready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp.ready <= (phase % 4 == 0);
               end
               default: begin
                  rsp.ready <= ($urandom_range(0, 15) == 0);
               end
            endcase
            @(posedge clock);
         end
      end
   end

   // Present one sample and hold it until accepted; drop valid only when a gap follows.
   task offer_sample(value_type v, logic last);
      int gap;
      gap = 0;
      req.valid        <= 1'b1;
      req.sample_value <= v;
      req.is_final     <= last;
      do @(posedge clock); while (!req.ready);
      if (!gapless) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
         end else begin
            burst_left--;
         end
      end
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task send_list();
      int i;
      for (i = 0; i < list_buf.size(); i++)
         offer_sample(list_buf[i], i == list_buf.size() - 1);
   endtask

   // Pause the sender until every predicted result has come back.
   task wait_results();
      req.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function value_type pick_value();
      case ($urandom_range(0, 3))
         0: return value_type'(int'($urandom_range(0, 15)) - 8);
         1: return ($urandom_range(0, 1) != 0) ? VALUE_MIN : VALUE_MAX;
         default: return value_type'($urandom);
      endcase
   endfunction

   // Fill list_buf with len samples drawn from a pool of pool_size values.
   task make_list(int len, int pool_size);
      int i;
      value_pool.delete();
      list_buf.delete();
      for (i = 0; i < pool_size; i++) value_pool.push_back(pick_value());
      for (i = 0; i < len; i++)
         list_buf.push_back(value_pool[$urandom_range(0, pool_size - 1)]);
   endtask

   initial begin : stimulus
      int len;
      int n;
      req.valid        <= 1'b0;
      req.sample_value <= '0;
      req.is_final     <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: single-sample lists at both extremes (one distinct value).
      list_buf = '{VALUE_MIN};
      send_list();
      list_buf = '{VALUE_MAX};
      send_list();
      // All samples equal.
      list_buf = '{5, 5, 5};
      send_list();
      // Full tie: earliest first occurrence wins both ways.
      list_buf = '{-1, 0, -1, 0};
      send_list();
      // Distinct counts 3, 2, 1 in first-occurrence order.
      list_buf = '{7, 3, 3, 9, 7, 7};
      send_list();
      list_buf = '{VALUE_MIN, VALUE_MAX, VALUE_MAX, 1, VALUE_MIN, 1, 1};
      send_list();
      list_buf = '{value_type'(32'h5555_5555), value_type'(32'hAAAA_AAAA)};
      send_list();
      wait_results();

      // Long receiver hold-off while several short lists keep coming, so the
      // output register fills and the block stalls its input.
      hold_requested = 1'b1;
      gapless = 1'b1;
      repeat (5) begin
         make_list($urandom_range(2, 5), $urandom_range(1, 3));
         send_list();
      end
      gapless = 1'b0;
      wait_results();

      // Exactly full store of one value, final sample kept: widest count.
      list_buf.delete();
      repeat (CAPACITY) list_buf.push_back(value_type'($urandom));
      for (n = 1; n < CAPACITY; n++) list_buf[n] = list_buf[0];
      send_list();
      // Overflow: extra samples, the final one included, are dropped.
      make_list(CAPACITY + $urandom_range(1, 5), 4);
      send_list();
      wait_results();
      // Overflow by one on a list drawn from a pool of 200 values.
      make_list(CAPACITY + 1, 200);
      send_list();

      // Random lists: mostly short, with repeats from a small pool.
      while (random_items < RANDOM_ITEMS) begin
         gapless = ($urandom_range(0, 3) == 0);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         make_list(len, $urandom_range(1, len));
         send_list();
         random_items += len;
         if ($urandom_range(0, 14) == 0) wait_results();
      end

      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

### files.f
hdl/mfv_pkg.sv
hdl/mfv_if.sv
hdl/mfv_store.sv
hdl/most_and_least_frequent_value_top.sv
tb/testbench.sv
